// ===== sv/mfek_pkg.sv =====
package mfek_pkg;

  localparam int NODES  = 64;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = NODE_W + 1;
  localparam int CAP_W  = 16;
  localparam int RES_W  = CAP_W + 1;
  localparam int FLOW_W = 22;
  localparam int ADDR_W = 2 * NODE_W;
  localparam int CELLS  = NODES * NODES;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
  localparam logic [1:0] REG_SOURCE_NODE = 2'd1;
  localparam logic [1:0] REG_SINK_NODE   = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLR_STEP,
    CMD_RUN_START,
    CMD_BFS_INIT,
    CMD_POP_TAKE,
    CMD_SCAN,
    CMD_WALK_INIT,
    CMD_WALK_RESTART,
    CMD_NECK_USE,
    CMD_REV_RD,
    CMD_REV_WR,
    CMD_FWD_WR,
    CMD_ADD_TOTAL,
    CMD_OUT_LOAD
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic run_bad;
    logic q_empty;
    logic sink_seen;
    logic scan_done;
    logic walk_done;
    logic out_busy;
  } stat_t;

endpackage

// ===== sv/mfek_if.sv =====
interface mfek_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [mfek_pkg::NODE_W-1:0]  from_node;
  logic [mfek_pkg::NODE_W-1:0]  to_node;
  logic [mfek_pkg::CAP_W-1:0]   capacity;

  modport source (output valid, mode, from_node, to_node, capacity, input ready);
  modport sink (input valid, mode, from_node, to_node, capacity, output ready);
endinterface

interface mfek_out_if;
  logic                         valid;
  logic                         ready;
  logic [mfek_pkg::FLOW_W-1:0]  max_flow;

  modport source (output valid, max_flow, input ready);
  modport sink (input valid, max_flow, output ready);
endinterface

// ===== sv/mfek_ctrl.sv =====
module mfek_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [1:0]           in_mode,
  input  mfek_pkg::stat_t      stat,
  output logic                 in_ready,
  output mfek_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_POP, S_TAKE, S_SCAN, S_NECK_RD, S_NECK_USE,
    S_UPD_RD, S_REV_RD, S_REV_WR, S_FWD_WR, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = mfek_pkg::CMD_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd = mfek_pkg::CMD_CLR_STEP;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          priority case (in_mode)
            mfek_pkg::MODE_LOAD:  cmd = mfek_pkg::CMD_LOAD;
            mfek_pkg::MODE_CLEAR: state_next = S_CLEAR;
            mfek_pkg::MODE_RUN: begin
              cmd        = mfek_pkg::CMD_RUN_START;
              state_next = S_CHECK;
            end
            default: cmd = mfek_pkg::CMD_NONE;
          endcase
        end
      end
      S_CHECK: begin
        if (stat.run_bad) begin
          state_next = S_DONE;
        end else begin
          cmd        = mfek_pkg::CMD_BFS_INIT;
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (stat.sink_seen) begin
          cmd        = mfek_pkg::CMD_WALK_INIT;
          state_next = S_NECK_RD;
        end else if (stat.q_empty) begin
          state_next = S_DONE;
        end else begin
          state_next = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd        = mfek_pkg::CMD_POP_TAKE;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) state_next = S_POP;
        else cmd = mfek_pkg::CMD_SCAN;
      end
      S_NECK_RD: begin
        if (stat.walk_done) begin
          cmd        = mfek_pkg::CMD_WALK_RESTART;
          state_next = S_UPD_RD;
        end else begin
          state_next = S_NECK_USE;
        end
      end
      S_NECK_USE: begin
        cmd        = mfek_pkg::CMD_NECK_USE;
        state_next = S_NECK_RD;
      end
      S_UPD_RD: begin
        if (stat.walk_done) begin
          cmd        = mfek_pkg::CMD_ADD_TOTAL;
          state_next = S_CHECK;
        end else begin
          state_next = S_REV_RD;
        end
      end
      S_REV_RD: begin
        cmd        = mfek_pkg::CMD_REV_RD;
        state_next = S_REV_WR;
      end
      S_REV_WR: begin
        cmd        = mfek_pkg::CMD_REV_WR;
        state_next = S_FWD_WR;
      end
      S_FWD_WR: begin
        cmd        = mfek_pkg::CMD_FWD_WR;
        state_next = S_UPD_RD;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd        = mfek_pkg::CMD_OUT_LOAD;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

endmodule

// ===== sv/mfek_dp.sv =====
module mfek_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  mfek_pkg::cmd_t                cmd,
  input  logic [mfek_pkg::NODE_W-1:0]   from_node,
  input  logic [mfek_pkg::NODE_W-1:0]   to_node,
  input  logic [mfek_pkg::CAP_W-1:0]    capacity,
  input  logic [mfek_pkg::CNT_W-1:0]    node_count,
  input  logic [mfek_pkg::NODE_W-1:0]   source_node,
  input  logic [mfek_pkg::NODE_W-1:0]   sink_node,
  output mfek_pkg::stat_t               stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mfek_pkg::FLOW_W-1:0]   max_flow
);

  localparam int NW = mfek_pkg::NODE_W;
  localparam int CW = mfek_pkg::CNT_W;
  localparam int RW = mfek_pkg::RES_W;
  localparam int AW = mfek_pkg::ADDR_W;
  localparam int FW = mfek_pkg::FLOW_W;
  localparam int PW = NW + RW;

  logic [RW-1:0] res_mem [mfek_pkg::CELLS];
  logic [RW-1:0] res_q, res_wdata;
  logic [AW-1:0] res_raddr, res_waddr;
  logic          res_we;

  // parent node and edge weight per node
  logic [PW-1:0] pp_mem [mfek_pkg::NODES];
  logic [PW-1:0] pp_q;
  logic          pp_we;

  logic [NW-1:0] q_mem [mfek_pkg::NODES];
  logic [NW-1:0] q_q, q_wdata;
  logic [NW-1:0] q_waddr;
  logic          q_we;

  logic [mfek_pkg::NODES-1:0] visited;
  logic [CW-1:0] head, tail, scan_v, steps, n_eff;
  logic [NW-1:0] u, cur, pv_v, parent;
  logic          pv, take_edge;
  logic [RW-1:0] neck, pw, back_sat;
  logic [RW:0]   back;
  logic [FW-1:0] total;
  logic [FW:0]   total_sum;
  logic [AW-1:0] clr_addr;

  assign n_eff = (node_count > CW'(mfek_pkg::NODES)) ? CW'(mfek_pkg::NODES) : node_count;
  assign parent = pp_q[PW-1:RW];
  assign pw = pp_q[RW-1:0];
  assign back = {1'b0, res_q} + {1'b0, neck};
  assign back_sat = back[RW] ? {RW{1'b1}} : back[RW-1:0];
  assign total_sum = {1'b0, total} + (FW+1)'(neck);
  assign take_edge = pv && (res_q != '0) && !visited[pv_v];

  assign stat.clr_last = (clr_addr == {AW{1'b1}});
  assign stat.run_bad = (n_eff == '0) || ({1'b0, source_node} >= n_eff) ||
                        ({1'b0, sink_node} >= n_eff) || (source_node == sink_node);
  assign stat.q_empty = (head == tail);
  assign stat.sink_seen = visited[sink_node];
  assign stat.scan_done = (scan_v == n_eff) && !pv;
  assign stat.walk_done = (cur == source_node) || (steps >= n_eff);
  assign stat.out_busy = out_valid && !out_ready;

  always_comb begin
    res_we    = 1'b0;
    res_waddr = '0;
    res_wdata = '0;
    res_raddr = '0;
    unique case (cmd)
      mfek_pkg::CMD_CLR_STEP: begin
        res_we    = 1'b1;
        res_waddr = clr_addr;
      end
      mfek_pkg::CMD_LOAD: begin
        res_we    = 1'b1;
        res_waddr = {from_node, to_node};
        res_wdata = {1'b0, capacity};
      end
      mfek_pkg::CMD_SCAN: res_raddr = {u, scan_v[NW-1:0]};
      mfek_pkg::CMD_REV_RD: res_raddr = {cur, parent};
      mfek_pkg::CMD_REV_WR: begin
        res_we    = 1'b1;
        res_waddr = {cur, u};
        res_wdata = back_sat;
        res_raddr = {u, cur};
      end
      mfek_pkg::CMD_FWD_WR: begin
        res_we    = 1'b1;
        res_waddr = {u, cur};
        res_wdata = res_q - neck;
      end
      default: res_raddr = '0;
    endcase
  end

  always_comb begin
    q_we    = 1'b0;
    q_waddr = tail[NW-1:0];
    q_wdata = pv_v;
    pp_we   = 1'b0;
    if (cmd == mfek_pkg::CMD_BFS_INIT) begin
      q_we    = 1'b1;
      q_waddr = '0;
      q_wdata = source_node;
    end else if (cmd == mfek_pkg::CMD_SCAN && take_edge) begin
      q_we  = 1'b1;
      pp_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_waddr] <= res_wdata;
    res_q <= res_mem[res_raddr];
    if (pp_we) pp_mem[pv_v] <= {u, res_q};
    pp_q <= pp_mem[cur];
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_q <= q_mem[head[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      visited   <= '0;
      head      <= '0;
      tail      <= '0;
      scan_v    <= '0;
      pv        <= 1'b0;
      steps     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd == mfek_pkg::CMD_OUT_LOAD) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      pv <= (cmd == mfek_pkg::CMD_SCAN) && (scan_v < n_eff);
      unique case (cmd)
        mfek_pkg::CMD_CLR_STEP: clr_addr <= clr_addr + 1'b1;
        mfek_pkg::CMD_RUN_START: total <= '0;
        mfek_pkg::CMD_BFS_INIT: begin
          visited <= {{(mfek_pkg::NODES-1){1'b0}}, 1'b1} << source_node;
          head    <= '0;
          tail    <= CW'(1);
        end
        mfek_pkg::CMD_POP_TAKE: begin
          u      <= q_q;
          head   <= head + 1'b1;
          scan_v <= '0;
        end
        mfek_pkg::CMD_SCAN: begin
          if (scan_v < n_eff) begin
            pv_v   <= scan_v[NW-1:0];
            scan_v <= scan_v + 1'b1;
          end
          if (take_edge) begin
            visited[pv_v] <= 1'b1;
            tail <= tail + 1'b1;
          end
        end
        mfek_pkg::CMD_WALK_INIT: begin
          cur   <= sink_node;
          steps <= '0;
          neck  <= {RW{1'b1}};
        end
        mfek_pkg::CMD_WALK_RESTART: begin
          cur   <= sink_node;
          steps <= '0;
        end
        mfek_pkg::CMD_NECK_USE: begin
          if (pw < neck) neck <= pw;
          cur   <= parent;
          steps <= steps + 1'b1;
        end
        mfek_pkg::CMD_REV_RD: u <= parent;
        mfek_pkg::CMD_FWD_WR: begin
          cur   <= u;
          steps <= steps + 1'b1;
        end
        mfek_pkg::CMD_ADD_TOTAL: total <= total_sum[FW] ? {FW{1'b1}} : total_sum[FW-1:0];
        mfek_pkg::CMD_OUT_LOAD: max_flow <= total;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/max_flow_edmonds_karp_top.sv =====
// Load item: written to the matrix on accept. Clear item: one matrix entry per cycle after accept.
// Run item: breadth-first searches and path updates over the node count in use, paced by the
//   single matrix read port; bad terminals skip the search and give a zero result.
// Items are taken one at a time; a result waits in an output register.
// Reset (synchronous) starts a clearing pass over all 4096 matrix entries;
//   no item is taken until it ends, configuration writes are taken at once.
module max_flow_edmonds_karp_top (
  input  logic        clk,
  input  logic        rst,
  mfek_in_if.sink     item,
  mfek_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [mfek_pkg::CNT_W-1:0]  node_count;
  logic [mfek_pkg::NODE_W-1:0] source_node, sink_node;
  logic [1:0]                  reg_idx;
  mfek_pkg::cmd_t              cmd;
  mfek_pkg::stat_t             stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= mfek_pkg::CNT_W'(mfek_pkg::NODES);
      source_node <= '0;
      sink_node   <= mfek_pkg::NODE_W'(mfek_pkg::NODES - 1);
    end else if (psel && penable && pwrite) begin
      priority case (reg_idx)
        mfek_pkg::REG_NODE_COUNT:  node_count  <= pwdata[mfek_pkg::CNT_W-1:0];
        mfek_pkg::REG_SOURCE_NODE: source_node <= pwdata[mfek_pkg::NODE_W-1:0];
        mfek_pkg::REG_SINK_NODE:   sink_node   <= pwdata[mfek_pkg::NODE_W-1:0];
        default: node_count <= node_count;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mfek_pkg::REG_NODE_COUNT:  prdata = 32'(node_count);
      mfek_pkg::REG_SOURCE_NODE: prdata = 32'(source_node);
      mfek_pkg::REG_SINK_NODE:   prdata = 32'(sink_node);
      default: prdata = '0;
    endcase
  end

  mfek_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_mode  (item.mode),
    .stat     (stat),
    .in_ready (item.ready),
    .cmd      (cmd)
  );

  mfek_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .from_node   (item.from_node),
    .to_node     (item.to_node),
    .capacity    (item.capacity),
    .node_count  (node_count),
    .source_node (source_node),
    .sink_node   (sink_node),
    .stat        (stat),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .max_flow    (result.max_flow)
  );

endmodule
